// File: sv/lifetime_best_fit_slot_planner_core_macros.svh
// Assertion macros used by the checker file of the slot planner.
`ifndef LIFETIME_BEST_FIT_SLOT_PLANNER_CORE_MACROS_SVH
`define LIFETIME_BEST_FIT_SLOT_PLANNER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LBFSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LBFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lbfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfsp_pkg
// Types, constants and compare functions of the slot planner.
// ----------------------------------------------------------------------------
package lbfsp_pkg;

	localparam int MAX_TENSORS = 64;
	localparam int IDX_W       = $clog2(MAX_TENSORS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int FIRST_W     = 12;
	localparam int LAST_W      = 13;
	localparam int SIZE_W      = 32;
	localparam int OFF_W       = 40;
	localparam int OUT_OFF_W   = 39;
	localparam int ALIGN_W     = 4;
	localparam int MAX_NODES   = 4096;
	localparam int ALIGN_MAX   = 12;
	localparam int ALIGN_RST   = 6;

	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [LAST_W-1:0]  last;
		logic [SIZE_W-1:0]  bytes;
	} life_t;

	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [LAST_W-1:0]  last;
		logic [IDX_W-1:0]   slot;
	} plan_t;

	typedef struct packed {
		logic [OFF_W-1:0]  base;
		logic [SIZE_W-1:0] size;
	} slot_t;

	typedef struct packed {
		logic             start;
		logic             run;
		logic [CNT_W-1:0] limit;
	} sweep_ctl_t;

	typedef struct packed {
		logic [IDX_W-1:0] raddr;
		logic             v;
		logic [IDX_W-1:0] idx;
		logic             done;
	} sweep_sts_t;

	// True if tensor p comes before tensor q in planning order.
	function automatic logic goes_before(life_t p, logic [IDX_W-1:0] pi,
			life_t q, logic [IDX_W-1:0] qi);
		logic r;
		if (p.bytes != q.bytes) begin
			r = p.bytes > q.bytes;
		end else if (p.first != q.first) begin
			r = p.first < q.first;
		end else begin
			r = pi < qi;
		end
		return r;
	endfunction

	// Two lifetimes clash unless one ends no later than the other starts.
	function automatic logic lives_clash(logic [FIRST_W-1:0] f1, logic [LAST_W-1:0] l1,
			logic [FIRST_W-1:0] f2, logic [LAST_W-1:0] l2);
		return !((l1 <= LAST_W'(f2)) || (l2 <= LAST_W'(f1)));
	endfunction

endpackage

// File: sv/lbfsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/lbfsp_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfsp_sweep
// Address sequencer that walks a memory from zero up to one below a limit,
// one read per cycle while run is high, and tags the returning data with
// its index.
module lbfsp_sweep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lbfsp_pkg::sweep_ctl_t  ctl,
	output lbfsp_pkg::sweep_sts_t  sts
);

	logic [lbfsp_pkg::CNT_W-1:0] iss_q;
	logic                        v_q;
	logic [lbfsp_pkg::IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			v_q   <= 1'b0;
			idx_q <= '0;
		end else if (ctl.start) begin
			iss_q <= '0;
			v_q   <= 1'b0;
		end else if (ctl.run) begin
			if (iss_q < ctl.limit) begin
				iss_q <= iss_q + 1'b1;
				v_q   <= 1'b1;
				idx_q <= iss_q[lbfsp_pkg::IDX_W-1:0];
			end else begin
				v_q <= 1'b0;
			end
		end
	end

	assign sts.raddr = iss_q[lbfsp_pkg::IDX_W-1:0];
	assign sts.v     = v_q;
	assign sts.idx   = idx_q;
	assign sts.done  = ctl.run && (iss_q == ctl.limit) && !v_q;

endmodule

// File: sv/lifetime_best_fit_slot_planner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifetime_best_fit_slot_planner_core
// Collects tensor lifetimes and plans a shared arena by greedy best fit.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (req_valid, req_stall), one lifetime
// each, and are taken one per cycle while the block is loading. A request
// with last_item set starts planning; req_stall stays high from then until
// the last result of the plan has been taken.
// Planning first ranks every tensor against all others, then places each
// tensor in sorted order: a sweep over the already placed tensors to find
// clashing slots, then a sweep over the open slots to pick the smallest
// fitting one.
// Both sweeps share one address sequencer and read one memory word a cycle.
// Results then leave on the res channel in arrival order, one at a time;
// a stalled result holds its fields until res_stall is low.
// The register alignment_log2 is written through cfg_we / cfg_wdata.
// Reset clears the counters and control state; the memories need no clearing.
// ----------------------------------------------------------------------------
module lifetime_best_fit_slot_planner_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [11:0] first_node,
	input  logic [12:0] last_node,
	input  logic [31:0] byte_size,
	input  logic        last_item,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [5:0]  tensor_index,
	output logic [38:0] slot_offset,
	output logic [31:0] slot_bytes,
	output logic [38:0] arena_bytes,
	output logic        overflow,
	output logic        end_of_plan
);

	localparam int IW = lbfsp_pkg::IDX_W;
	localparam int CW = lbfsp_pkg::CNT_W;
	localparam int OW = lbfsp_pkg::OFF_W;

	typedef enum logic [3:0] {
		ST_LOAD, ST_R_FETCH, ST_R_LATCH, ST_R_SWEEP,
		ST_P_ORD, ST_P_ORDW, ST_P_LAT, ST_P_CLASH, ST_P_SLOT, ST_P_ASSIGN,
		ST_O_RD, ST_O_LOAD, ST_O_WAIT
	} state_t;

	state_t                          state_q;
	logic [lbfsp_pkg::ALIGN_W-1:0]   align_q;
	logic [CW-1:0]                   tcount_q;
	logic                            ovf_q;
	logic [CW-1:0]                   pos_q;
	logic [CW-1:0]                   rank_q;
	logic [IW-1:0]                   cur_t_q;
	lbfsp_pkg::life_t                cur_life_q;
	logic [CW-1:0]                   slots_q;
	logic [OW-1:0]                   total_q;
	logic [lbfsp_pkg::MAX_TENSORS-1:0] blocked_q;
	logic                            found_q;
	logic [IW-1:0]                   best_q;
	logic [lbfsp_pkg::SIZE_W-1:0]    best_size_q;
	logic [OW-1:0]                   best_base_q;
	logic                            res_valid_q;
	logic [5:0]                      tensor_index_q;
	logic [38:0]                     slot_offset_q;
	logic [31:0]                     slot_bytes_q;
	logic [38:0]                     arena_bytes_q;
	logic                            overflow_q;
	logic                            end_of_plan_q;

	lbfsp_pkg::sweep_ctl_t sw_ctl;
	lbfsp_pkg::sweep_sts_t sw_sts;

	logic             life_we;
	lbfsp_pkg::life_t life_wdata, life_rdata;
	logic [IW-1:0]    life_raddr;
	logic             order_we;
	logic [IW-1:0]    order_rdata;
	logic             plan_we;
	lbfsp_pkg::plan_t plan_wdata, plan_rdata;
	logic             slot_we;
	lbfsp_pkg::slot_t slot_wdata, slot_rdata;
	logic [OW-1:0]    off_rdata;

	logic             accept;
	logic             has_room;
	logic [3:0]       sh;
	logic [OW-1:0]    align_mask;
	logic [OW-1:0]    new_off;
	logic [OW-1:0]    assign_off;
	logic [IW-1:0]    assign_slot;
	logic             pos_last;

	assign accept   = req_valid && !req_stall;
	assign has_room = tcount_q < CW'(lbfsp_pkg::MAX_TENSORS);
	assign pos_last = (pos_q + 1'b1) == tcount_q;

	// Alignment above the supported maximum saturates.
	assign sh         = (align_q > 4'(lbfsp_pkg::ALIGN_MAX)) ? 4'(lbfsp_pkg::ALIGN_MAX) : align_q;
	assign align_mask = ~({OW{1'b1}} << sh);
	assign new_off    = (total_q + align_mask) & ~align_mask;
	assign assign_off = found_q ? best_base_q : new_off;
	assign assign_slot = found_q ? best_q : slots_q[IW-1:0];

	// Stored lifetime: last use saturates at the node count.
	always_comb begin
		life_wdata.first = first_node;
		life_wdata.last  = (last_node > 13'(lbfsp_pkg::MAX_NODES)) ?
			13'(lbfsp_pkg::MAX_NODES) : last_node;
		life_wdata.bytes = byte_size;
	end
	assign life_we = accept && has_room;

	always_comb begin
		case (state_q)
			ST_R_SWEEP: life_raddr = sw_sts.raddr;
			ST_P_ORDW:  life_raddr = order_rdata;
			default:    life_raddr = pos_q[IW-1:0];
		endcase
	end

	// The shared sweep serves the rank pass, the clash pass and the slot search.
	always_comb begin
		sw_ctl.start = (state_q == ST_R_LATCH) || (state_q == ST_P_LAT) ||
			((state_q == ST_P_CLASH) && sw_sts.done);
		sw_ctl.run   = (state_q == ST_R_SWEEP) || (state_q == ST_P_CLASH) ||
			(state_q == ST_P_SLOT);
		case (state_q)
			ST_R_SWEEP: sw_ctl.limit = tcount_q;
			ST_P_CLASH: sw_ctl.limit = pos_q;
			default:    sw_ctl.limit = slots_q;
		endcase
	end

	assign order_we = (state_q == ST_R_SWEEP) && sw_sts.done;
	assign plan_we  = state_q == ST_P_ASSIGN;
	assign slot_we  = (state_q == ST_P_ASSIGN) && !found_q;

	always_comb begin
		plan_wdata.first = cur_life_q.first;
		plan_wdata.last  = cur_life_q.last;
		plan_wdata.slot  = assign_slot;
		slot_wdata.base  = new_off;
		slot_wdata.size  = cur_life_q.bytes;
	end

	lbfsp_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sw_ctl),
		.sts    (sw_sts)
	);

	// Lifetimes by arrival position.
	lbfsp_ram #(.WIDTH($bits(lbfsp_pkg::life_t)), .DEPTH(lbfsp_pkg::MAX_TENSORS)) u_life (
		.clk   (clk),
		.we    (life_we),
		.waddr (tcount_q[IW-1:0]),
		.wdata (life_wdata),
		.raddr (life_raddr),
		.rdata (life_rdata)
	);

	// Arrival position by planning rank.
	lbfsp_ram #(.WIDTH(IW), .DEPTH(lbfsp_pkg::MAX_TENSORS)) u_order (
		.clk   (clk),
		.we    (order_we),
		.waddr (rank_q[IW-1:0]),
		.wdata (pos_q[IW-1:0]),
		.raddr (pos_q[IW-1:0]),
		.rdata (order_rdata)
	);

	// Placed tensors by planning rank: lifetime and chosen slot.
	lbfsp_ram #(.WIDTH($bits(lbfsp_pkg::plan_t)), .DEPTH(lbfsp_pkg::MAX_TENSORS)) u_plan (
		.clk   (clk),
		.we    (plan_we),
		.waddr (pos_q[IW-1:0]),
		.wdata (plan_wdata),
		.raddr (sw_sts.raddr),
		.rdata (plan_rdata)
	);

	// Open slots: base offset and size.
	lbfsp_ram #(.WIDTH($bits(lbfsp_pkg::slot_t)), .DEPTH(lbfsp_pkg::MAX_TENSORS)) u_slot (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slots_q[IW-1:0]),
		.wdata (slot_wdata),
		.raddr (sw_sts.raddr),
		.rdata (slot_rdata)
	);

	// Final offset of each tensor by arrival position.
	lbfsp_ram #(.WIDTH(OW), .DEPTH(lbfsp_pkg::MAX_TENSORS)) u_off (
		.clk   (clk),
		.we    (plan_we),
		.waddr (cur_t_q),
		.wdata (assign_off),
		.raddr (pos_q[IW-1:0]),
		.rdata (off_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			align_q     <= 4'(lbfsp_pkg::ALIGN_RST);
			tcount_q    <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			slots_q     <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				align_q <= cfg_wdata;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							tcount_q <= tcount_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							pos_q   <= '0;
							state_q <= ST_R_FETCH;
						end
					end
				end
				ST_R_FETCH: begin
					state_q <= ST_R_LATCH;
				end
				ST_R_LATCH: begin
					cur_life_q <= life_rdata;
					rank_q     <= '0;
					state_q    <= ST_R_SWEEP;
				end
				ST_R_SWEEP: begin
					// Rank is the number of tensors that go before this one.
					if (sw_sts.v && lbfsp_pkg::goes_before(life_rdata, sw_sts.idx,
							cur_life_q, pos_q[IW-1:0])) begin
						rank_q <= rank_q + 1'b1;
					end
					if (sw_sts.done) begin
						if (pos_last) begin
							pos_q   <= '0;
							state_q <= ST_P_ORD;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_R_FETCH;
						end
					end
				end
				ST_P_ORD: begin
					state_q <= ST_P_ORDW;
				end
				ST_P_ORDW: begin
					cur_t_q <= order_rdata;
					state_q <= ST_P_LAT;
				end
				ST_P_LAT: begin
					cur_life_q <= life_rdata;
					blocked_q  <= '0;
					state_q    <= ST_P_CLASH;
				end
				ST_P_CLASH: begin
					if (sw_sts.v && lbfsp_pkg::lives_clash(cur_life_q.first, cur_life_q.last,
							plan_rdata.first, plan_rdata.last)) begin
						blocked_q[plan_rdata.slot] <= 1'b1;
					end
					if (sw_sts.done) begin
						found_q <= 1'b0;
						state_q <= ST_P_SLOT;
					end
				end
				ST_P_SLOT: begin
					// Smallest free slot that is large enough; earlier wins ties.
					if (sw_sts.v && !blocked_q[sw_sts.idx] &&
							(slot_rdata.size >= cur_life_q.bytes) &&
							(!found_q || (slot_rdata.size < best_size_q))) begin
						found_q     <= 1'b1;
						best_q      <= sw_sts.idx;
						best_size_q <= slot_rdata.size;
						best_base_q <= slot_rdata.base;
					end
					if (sw_sts.done) begin
						state_q <= ST_P_ASSIGN;
					end
				end
				ST_P_ASSIGN: begin
					if (!found_q) begin
						slots_q <= slots_q + 1'b1;
						total_q <= new_off + OW'(cur_life_q.bytes);
					end
					if (pos_last) begin
						pos_q   <= '0;
						state_q <= ST_O_RD;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= ST_P_ORD;
					end
				end
				ST_O_RD: begin
					state_q <= ST_O_LOAD;
				end
				ST_O_LOAD: begin
					tensor_index_q <= pos_q[5:0];
					slot_offset_q  <= off_rdata[38:0];
					slot_bytes_q   <= life_rdata.bytes;
					arena_bytes_q  <= total_q[38:0];
					overflow_q     <= ovf_q;
					end_of_plan_q  <= pos_last;
					res_valid_q    <= 1'b1;
					state_q        <= ST_O_WAIT;
				end
				ST_O_WAIT: begin
					if (!res_stall) begin
						res_valid_q <= 1'b0;
						if (end_of_plan_q) begin
							tcount_q <= '0;
							ovf_q    <= 1'b0;
							slots_q  <= '0;
							total_q  <= '0;
							state_q  <= ST_LOAD;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_O_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign req_stall    = state_q != ST_LOAD;
	assign res_valid    = res_valid_q;
	assign tensor_index = tensor_index_q;
	assign slot_offset  = slot_offset_q;
	assign slot_bytes   = slot_bytes_q;
	assign arena_bytes  = arena_bytes_q;
	assign overflow     = overflow_q;
	assign end_of_plan  = end_of_plan_q;

endmodule

// File: sv/lbfsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfsp_checker
// Port-level checks of the slot planner, bound to the top level.
// ----------------------------------------------------------------------------
`include "lifetime_best_fit_slot_planner_core_macros.svh"

module lbfsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [38:0] slot_offset,
	input logic        end_of_plan
);

	// A stalled result keeps its offset and stays valid.
	`LBFSP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(slot_offset), "stalled result changed")

	// No request is taken while a result is on offer.
	`LBFSP_ASSERT_NOW(a_busy_out, res_valid, req_stall, "request side open during results")

	// After the final result the block is free to load again.
	`LBFSP_ASSERT_NEXT(a_plan_end, res_valid && !res_stall && end_of_plan, !res_valid && !req_stall, "plan did not close")

	// A result that is not the last keeps the request side closed.
	`LBFSP_ASSERT_NEXT(a_plan_mid, res_valid && !res_stall && !end_of_plan, req_stall, "plan ended early")

endmodule

bind lifetime_best_fit_slot_planner_core lbfsp_checker u_lbfsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_stall   (req_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.slot_offset (slot_offset),
	.end_of_plan (end_of_plan)
);

// File: bench/lifetime_best_fit_slot_planner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifetime_best_fit_slot_planner_core_tb
// Checks the arena planner against a greedy best fit plan built here.
// ----------------------------------------------------------------------------
// Each plan is a batch of lifetime requests that ends with last_item. When a
// batch is complete, the bench works out its plan in the same way the block
// should: order by size descending, then first use, then arrival order.
// Each tensor goes to the smallest free slot that fits, or else to a new
// aligned slot. One expected result per stored tensor is queued in arrival
// order. Results are compared field by field as they are taken. Both sides
// pause at random. The alignment register is written only while the block
// is idle.
// ----------------------------------------------------------------------------
module lifetime_best_fit_slot_planner_core_tb;

	localparam int CAP = 64;
	localparam int WATCHDOG = 200000;

	// One lifetime request as the driver presents it.
	typedef struct {
		logic [11:0] first;
		logic [12:0] last;
		logic [31:0] bytes;
		logic        fin;
	} life_req_t;

	// One planned placement as the monitor expects to see it.
	typedef struct {
		logic [5:0]  idx;
		logic [38:0] offset;
		logic [31:0] bytes;
		logic [38:0] arena;
		logic        ovf;
		logic        eop;
	} placement_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        req_valid;
	logic        req_stall;
	logic [11:0] first_node;
	logic [12:0] last_node;
	logic [31:0] byte_size;
	logic        last_item;
	logic        res_valid;
	logic        res_stall;
	logic [5:0]  tensor_index;
	logic [38:0] slot_offset;
	logic [31:0] slot_bytes;
	logic [38:0] arena_bytes;
	logic        overflow;
	logic        end_of_plan;

	lifetime_best_fit_slot_planner_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall), .first_node(first_node),
		.last_node(last_node), .byte_size(byte_size), .last_item(last_item),
		.res_valid(res_valid), .res_stall(res_stall), .tensor_index(tensor_index),
		.slot_offset(slot_offset), .slot_bytes(slot_bytes), .arena_bytes(arena_bytes),
		.overflow(overflow), .end_of_plan(end_of_plan)
	);

	// Requests waiting for the driver, and placements waiting for the monitor.
	life_req_t  pending_lives[$];
	placement_t planned_slots[$];

	// Planner shadow: the batch being collected and the alignment in force.
	logic [11:0] batch_first[CAP];
	logic [12:0] batch_last[CAP];
	logic [31:0] batch_bytes[CAP];
	int          batch_count = 0;
	logic        batch_overflow = 1'b0;
	logic [3:0]  align_log2;

	int  errors = 0;
	int  idle_cycles;
	bit  feeding_done;
	logic [31:0] req_gap, res_gap;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Most pauses are short; about one in sixteen is long.
	function automatic logic [31:0] pick_gap();
		logic [31:0] g;
		if ($urandom_range(0, 3) == 0) begin
			g = 0;
		end else if ($urandom_range(0, 11) == 0) begin
			g = $urandom_range(10, 40);
		end else begin
			g = $urandom_range(0, 3);
		end
		return g;
	endfunction

	// True when tensor p is placed ahead of tensor q.
	function automatic bit ranks_ahead(int p, int q);
		bit r;
		if (batch_bytes[p] != batch_bytes[q]) begin
			r = batch_bytes[p] > batch_bytes[q];
		end else if (batch_first[p] != batch_first[q]) begin
			r = batch_first[p] < batch_first[q];
		end else begin
			r = p < q;
		end
		return r;
	endfunction

	function automatic bit lifetimes_overlap(int p, int q);
		return !(batch_last[p] <= {1'b0, batch_first[q]} ||
			batch_last[q] <= {1'b0, batch_first[p]});
	endfunction

	// Plans the collected batch and queues one placement per tensor.
	task automatic plan_batch();
		int          order[CAP];
		int          slot_of[CAP];
		logic [39:0] base[CAP];
		logic [31:0] size[CAP];
		int          nslots, best, v, j;
		bit          ok;
		logic [39:0] total, off, mask;
		logic [3:0]  sh;
		placement_t  p;
		sh = (align_log2 > 4'd12) ? 4'd12 : align_log2;
		mask = (40'd1 << sh) - 40'd1;
		for (int i = 0; i < batch_count; i++) order[i] = i;
		for (int i = 1; i < batch_count; i++) begin
			v = order[i];
			j = i;
			while (j > 0 && ranks_ahead(v, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = v;
		end
		nslots = 0;
		total = '0;
		for (int i = 0; i < batch_count; i++) begin
			v = order[i];
			best = nslots;
			for (int s = 0; s < nslots; s++) begin
				ok = size[s] >= batch_bytes[v];
				for (int k = 0; k < i && ok; k++) begin
					if (slot_of[order[k]] == s && lifetimes_overlap(v, order[k])) ok = 0;
				end
				if (ok && (best == nslots || size[s] < size[best])) best = s;
			end
			if (best == nslots) begin
				off = (total + mask) & ~mask;
				base[best] = off;
				size[best] = batch_bytes[v];
				nslots++;
				total = off + batch_bytes[v];
			end
			slot_of[v] = best;
		end
		for (int t = 0; t < batch_count; t++) begin
			p.idx    = t[5:0];
			p.offset = base[slot_of[t]][38:0];
			p.bytes  = batch_bytes[t];
			p.arena  = total[38:0];
			p.ovf    = batch_overflow;
			p.eop    = (t == batch_count - 1);
			planned_slots.insert(planned_slots.size(), p);
		end
		batch_count = 0;
		batch_overflow = 0;
	endtask

	// Folds one accepted request into the shadow batch.
	task automatic take_life(life_req_t r);
		if (batch_count < CAP) begin
			batch_first[batch_count] = r.first;
			batch_last[batch_count]  = (r.last > 13'd4096) ? 13'd4096 : r.last;
			batch_bytes[batch_count] = r.bytes;
			batch_count++;
		end else begin
			batch_overflow = 1;
		end
		if (r.fin) plan_batch();
	endtask

	function automatic life_req_t rand_life(bit fin);
		life_req_t r;
		int f;
		f = $urandom_range(0, 4095);
		r.first = f[11:0];
		case ($urandom_range(0, 9))
			0: r.last = 13'($urandom_range(0, 8191));
			1: r.last = {1'b0, r.first};
			default: r.last = 13'(f + $urandom_range(1, 300));
		endcase
		case ($urandom_range(0, 7))
			0: r.bytes = $urandom;
			1: r.bytes = $urandom_range(0, 3);
			2: r.bytes = 32'd1 << $urandom_range(0, 31);
			default: r.bytes = $urandom_range(1, 4096);
		endcase
		r.fin = fin;
		return r;
	endfunction

	// Queues one plan of n tensors, the last one marked.
	task automatic queue_plan(int n);
		for (int i = 0; i < n; i++)
			pending_lives.insert(pending_lives.size(), rand_life(i == n - 1));
	endtask

	// Waits for the block to drain, then sets the alignment register.
	task automatic set_alignment(logic [3:0] value);
		wait (pending_lives.size() == 0 && !req_valid && planned_slots.size() == 0);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		align_log2 = value;
	endtask

	// Driver: presents queued requests with random gaps in between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req_gap    <= 0;
			first_node <= '0;
			last_node  <= '0;
			byte_size  <= '0;
			last_item  <= 1'b0;
		end else begin
			if (req_valid && !req_stall) take_life('{first_node, last_node, byte_size, last_item});
			if (!req_valid || !req_stall) begin
				if ((!req_valid || req_gap == 0) && req_gap != 0) begin
					req_gap <= req_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_lives.size() != 0 && req_gap == 0) begin
					first_node <= pending_lives[0].first;
					last_node  <= pending_lives[0].last;
					byte_size  <= pending_lives[0].bytes;
					last_item  <= pending_lives[0].fin;
					void'(pending_lives.pop_front());
					req_valid <= 1'b1;
					req_gap <= pick_gap();
				end else begin
					if (req_gap != 0) req_gap <= req_gap - 1;
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each taken result with the oldest placement.
	always @(posedge clk or negedge arst_n) begin
		placement_t e;
		if (!arst_n) begin
			res_stall <= 1'b1;
			res_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (planned_slots.size() == 0) begin
					$error("result with no placement waiting, tensor_index %0d", tensor_index);
					errors++;
				end else begin
					e = planned_slots.pop_front();
					if (tensor_index !== e.idx) begin
						$error("tensor_index expected %0d actual %0d", e.idx, tensor_index);
						errors++;
					end
					if (slot_offset !== e.offset) begin
						$error("slot_offset expected %0d actual %0d", e.offset, slot_offset);
						errors++;
					end
					if (slot_bytes !== e.bytes) begin
						$error("slot_bytes expected %0d actual %0d", e.bytes, slot_bytes);
						errors++;
					end
					if (arena_bytes !== e.arena) begin
						$error("arena_bytes expected %0d actual %0d", e.arena, arena_bytes);
						errors++;
					end
					if (overflow !== e.ovf) begin
						$error("overflow expected %0d actual %0d", e.ovf, overflow);
						errors++;
					end
					if (end_of_plan !== e.eop) begin
						$error("end_of_plan expected %0d actual %0d", e.eop, end_of_plan);
						errors++;
					end
				end
			end
			if ((res_valid && !res_stall) || (req_valid && !req_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (res_gap != 0) begin
				res_gap <= res_gap - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				res_gap <= pick_gap();
			end
		end
	end

	// Watchdog: a long stretch with nothing taken means the block is hung.
	always @(posedge clk) begin
		if (idle_cycles > WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		life_req_t r;
		align_log2 = 4'd6;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero sizes, ties, a reversed lifetime,
		// clamped last use and a lone tensor.
		pending_lives.insert(pending_lives.size(), '{12'd0, 13'd0, 32'd1, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd4095, 13'd8191, 32'hFFFF_FFFF, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd0, 13'd4096, 32'hFFFF_FFFF, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd10, 13'd5, 32'd0, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd5, 13'd10, 32'd100, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd10, 13'd20, 32'd100, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd5, 13'd10, 32'd100, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd2730, 13'd5461, 32'h5555_5555, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd1365, 13'd2730, 32'hAAAA_AAAA, 1'b1});
		pending_lives.insert(pending_lives.size(), '{12'd7, 13'd7, 32'd0, 1'b1});
		set_alignment(4'd0);
		pending_lives.insert(pending_lives.size(), '{12'd0, 13'd3, 32'd3, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd1, 13'd4, 32'd5, 1'b0});
		pending_lives.insert(pending_lives.size(), '{12'd3, 13'd9, 32'd2, 1'b1});
		set_alignment(4'd15);
		queue_plan(4);
		// Overflow: sixty-six requests, the dropped last one starts planning.
		set_alignment(4'd12);
		queue_plan(66);

		// Random plans, mostly short, across several alignments.
		for (int k = 0; k < 33; k++) begin
			if (k % 6 == 0) set_alignment(4'($urandom_range(0, 15)));
			queue_plan(($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
				: $urandom_range(1, 10));
		end
		set_alignment(4'd6);
		queue_plan(8);

		wait (pending_lives.size() == 0 && !req_valid && planned_slots.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && planned_slots.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: lifetime_best_fit_slot_planner_core.f
+incdir+sv
sv/lbfsp_pkg.sv
sv/lbfsp_ram.sv
sv/lbfsp_sweep.sv
sv/lifetime_best_fit_slot_planner_core.sv
sv/lbfsp_checker.sv
bench/lifetime_best_fit_slot_planner_core_tb.sv
